### rtl/fcce_pkg.sv
// Shared constants, types and helper functions of the formal context closure engine.
package fcce_pkg;

	localparam int MAX_OBJECTS    = 32;
	localparam int MAX_ATTRIBUTES = 32;

	// Count registers and walk counters are six bits wide, as the count fields are.
	localparam int CNT_W = 6;
	localparam int IDX_W = 5;
	localparam int RES_W = 32;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	localparam int OBJ_AW  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int ATTR_AW = (MAX_ATTRIBUTES > 1) ? $clog2(MAX_ATTRIBUTES) : 1;

	// A stored object row holds one bit per attribute, a column one bit per object.
	localparam int ROW_W = MAX_ATTRIBUTES;
	localparam int COL_W = MAX_OBJECTS;

	// Working sets are wide enough for either kind of set and for the result port.
	localparam int SET_MAX = (MAX_OBJECTS > MAX_ATTRIBUTES) ? MAX_OBJECTS : MAX_ATTRIBUTES;
	localparam int SET_W   = (SET_MAX > RES_W) ? SET_MAX : RES_W;

	localparam logic [2:0] KIND_WRITE_CELL  = 3'd0;
	localparam logic [2:0] KIND_READ_CELL   = 3'd1;
	localparam logic [2:0] KIND_OBJ_ROW     = 3'd2;
	localparam logic [2:0] KIND_ATTR_COL    = 3'd3;
	localparam logic [2:0] KIND_DERIVE_ATTR = 3'd4;
	localparam logic [2:0] KIND_DERIVE_OBJ  = 3'd5;
	localparam logic [2:0] KIND_CLOSE_ATTR  = 3'd6;
	localparam logic [2:0] KIND_CLOSE_OBJ   = 3'd7;

	localparam logic REG_OBJECT_COUNT    = 1'b0;
	localparam logic REG_ATTRIBUTE_COUNT = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef struct packed {
		logic [CNT_W-1:0] obj_cnt;
		logic [CNT_W-1:0] attr_cnt;
	} cfg_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [IDX_W-1:0] obj_index;
		logic [IDX_W-1:0] attr_index;
		logic             cell_value;
		logic [RES_W-1:0] query_set;
	} item_t;

	typedef struct packed {
		logic [RES_W-1:0] result_set;
		logic             cell_bit;
		logic             status;
	} res_t;

	// Ones in the positions below n.
	function automatic logic [SET_W-1:0] low_mask(input logic [CNT_W-1:0] n);
		logic [SET_W-1:0] m;
		for (int i = 0; i < SET_W; i++) begin
			m[i] = (i < int'(n));
		end
		return m;
	endfunction

	// A count beyond the store depth acts as the depth.
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n, input int lim);
		return (int'(n) > lim) ? CNT_W'(lim) : n;
	endfunction

endpackage

### rtl/fcce_ram.sv
// Generic single-port synchronous RAM with a registered read.
module fcce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                        wdata,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### rtl/fcce_cfg.sv
// Count registers behind the APB-style configuration port.
module fcce_cfg import fcce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [CNT_W-1:0] obj_count_q;
	logic [CNT_W-1:0] attr_count_q;
	logic             wr_en;

	// Byte address bits below the register index are ignored.
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_count_q  <= CNT_W'(32);
			attr_count_q <= CNT_W'(32);
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_OBJECT_COUNT:    obj_count_q  <= pwdata[CNT_W-1:0];
				REG_ATTRIBUTE_COUNT: attr_count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_OBJECT_COUNT:    prdata = CFG_DW'(obj_count_q);
			REG_ATTRIBUTE_COUNT: prdata = CFG_DW'(attr_count_q);
			default:             prdata = '0;
		endcase
	end

	assign cfg.obj_cnt  = clamp_count(obj_count_q, MAX_OBJECTS);
	assign cfg.attr_cnt = clamp_count(attr_count_q, MAX_ATTRIBUTES);

endmodule

### rtl/fcce_eng.sv
// Sequencer that reads, modifies and walks the row and column stores.
module fcce_eng import fcce_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  item_t item,
	input  cfg_t  cfg,
	output logic  idle,
	output logic  res_valid,
	input  logic  res_take,
	output res_t  res
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CELL = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]         st_q;
	logic [2:0]         kind_q;
	logic [IDX_W-1:0]   oi_q;
	logic [IDX_W-1:0]   ai_q;
	logic               val_q;
	logic [SET_W-1:0]   q_q;
	logic [SET_W-1:0]   acc_q;
	logic [SET_W-1:0]   res_set_q;
	logic               bit_q;
	logic               status_q;
	logic               phase_col_q;
	logic               second_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   idx_s1;
	logic               pend_s1;
	logic               row_v_s1;
	logic               col_v_s1;
	logic [MAX_OBJECTS-1:0]    row_vld_q;
	logic [MAX_ATTRIBUTES-1:0] col_vld_q;

	logic [OBJ_AW-1:0]  row_addr;
	logic [ATTR_AW-1:0] col_addr;
	logic [ROW_W-1:0]   row_mem;
	logic [COL_W-1:0]   col_mem;
	logic [ROW_W-1:0]   row_rd;
	logic [COL_W-1:0]   col_rd;
	logic [ROW_W-1:0]   row_bit;
	logic [COL_W-1:0]   col_bit;
	logic [ROW_W-1:0]   row_wdata;
	logic [COL_W-1:0]   col_wdata;
	logic               row_we;
	logic               col_we;
	logic [SET_W-1:0]   amask;
	logic [SET_W-1:0]   omask;
	logic [SET_W-1:0]   walk_data;
	logic [CNT_W-1:0]   limit;
	logic               hit;
	logic               obj_ok;
	logic               attr_ok;

	assign amask   = low_mask(cfg.attr_cnt);
	assign omask   = low_mask(cfg.obj_cnt);
	assign obj_ok  = CNT_W'(item.obj_index) < cfg.obj_cnt;
	assign attr_ok = CNT_W'(item.attr_index) < cfg.attr_cnt;

	always_comb begin
		row_addr = OBJ_AW'(item.obj_index);
		col_addr = ATTR_AW'(item.attr_index);
		if (st_q == S_WALK) begin
			row_addr = cnt_q[OBJ_AW-1:0];
			col_addr = cnt_q[ATTR_AW-1:0];
		end else if (st_q == S_CELL) begin
			row_addr = OBJ_AW'(oi_q);
			col_addr = ATTR_AW'(ai_q);
		end
	end

	// Entries never written since reset read as zero.
	assign row_rd = row_v_s1 ? row_mem : '0;
	assign col_rd = col_v_s1 ? col_mem : '0;

	assign row_bit   = ROW_W'(1) << ai_q;
	assign col_bit   = COL_W'(1) << oi_q;
	assign row_wdata = val_q ? (row_rd | row_bit) : (row_rd & ~row_bit);
	assign col_wdata = val_q ? (col_rd | col_bit) : (col_rd & ~col_bit);

	// The engine stays busy through the write, so no later read can overlap it.
	assign row_we = (st_q == S_CELL) && (kind_q == KIND_WRITE_CELL);
	assign col_we = row_we;

	fcce_ram #(.WIDTH(ROW_W), .DEPTH(MAX_OBJECTS)) u_rows (
		.clk   (clk),
		.we    (row_we),
		.addr  (row_addr),
		.wdata (row_wdata),
		.rdata (row_mem)
	);

	fcce_ram #(.WIDTH(COL_W), .DEPTH(MAX_ATTRIBUTES)) u_cols (
		.clk   (clk),
		.we    (col_we),
		.addr  (col_addr),
		.wdata (col_wdata),
		.rdata (col_mem)
	);

	assign limit     = phase_col_q ? cfg.attr_cnt : cfg.obj_cnt;
	assign walk_data = phase_col_q ? SET_W'(col_rd) : SET_W'(row_rd);
	// The query is already masked to the counts, so a plain subset test suffices.
	assign hit       = (q_q & ~walk_data) == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			kind_q      <= KIND_WRITE_CELL;
			oi_q        <= '0;
			ai_q        <= '0;
			val_q       <= 1'b0;
			q_q         <= '0;
			acc_q       <= '0;
			res_set_q   <= '0;
			bit_q       <= 1'b0;
			status_q    <= STATUS_OK;
			phase_col_q <= 1'b0;
			second_q    <= 1'b0;
			cnt_q       <= '0;
			idx_s1      <= '0;
			pend_s1     <= 1'b0;
			row_v_s1    <= 1'b0;
			col_v_s1    <= 1'b0;
			row_vld_q   <= '0;
			col_vld_q   <= '0;
		end else begin
			row_v_s1 <= row_vld_q[row_addr];
			col_v_s1 <= col_vld_q[col_addr];
			if (row_we) begin
				row_vld_q[row_addr] <= 1'b1;
				col_vld_q[col_addr] <= 1'b1;
			end
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						kind_q    <= item.kind;
						oi_q      <= item.obj_index;
						ai_q      <= item.attr_index;
						val_q     <= item.cell_value;
						cnt_q     <= '0;
						acc_q     <= '0;
						pend_s1   <= 1'b0;
						res_set_q <= '0;
						bit_q     <= 1'b0;
						status_q  <= STATUS_OK;
						unique case (item.kind)
							KIND_WRITE_CELL, KIND_READ_CELL: begin
								if (obj_ok && attr_ok) begin
									st_q <= S_CELL;
								end else begin
									status_q <= STATUS_RANGE;
									st_q     <= S_DONE;
								end
							end
							KIND_OBJ_ROW: begin
								if (obj_ok) begin
									st_q <= S_CELL;
								end else begin
									status_q <= STATUS_RANGE;
									st_q     <= S_DONE;
								end
							end
							KIND_ATTR_COL: begin
								if (attr_ok) begin
									st_q <= S_CELL;
								end else begin
									status_q <= STATUS_RANGE;
									st_q     <= S_DONE;
								end
							end
							KIND_DERIVE_ATTR, KIND_CLOSE_ATTR: begin
								phase_col_q <= 1'b0;
								second_q    <= (item.kind == KIND_CLOSE_ATTR);
								q_q         <= SET_W'(item.query_set) & amask;
								st_q        <= S_WALK;
							end
							KIND_DERIVE_OBJ, KIND_CLOSE_OBJ: begin
								phase_col_q <= 1'b1;
								second_q    <= (item.kind == KIND_CLOSE_OBJ);
								q_q         <= SET_W'(item.query_set) & omask;
								st_q        <= S_WALK;
							end
							default: ;
						endcase
					end
				end
				S_CELL: begin
					unique case (kind_q)
						KIND_READ_CELL: bit_q     <= |(row_rd & row_bit);
						KIND_OBJ_ROW:   res_set_q <= SET_W'(row_rd) & amask;
						KIND_ATTR_COL:  res_set_q <= SET_W'(col_rd) & omask;
						default: ;
					endcase
					st_q <= S_DONE;
				end
				S_WALK: begin
					if (pend_s1 && hit) begin
						acc_q <= acc_q | (SET_W'(1) << idx_s1);
					end
					if (cnt_q != limit) begin
						idx_s1  <= cnt_q;
						pend_s1 <= 1'b1;
						cnt_q   <= cnt_q + CNT_W'(1);
					end else begin
						pend_s1 <= 1'b0;
						// The pass ends once the last row or column read has been evaluated.
						if (!pend_s1) begin
							if (second_q) begin
								q_q         <= acc_q;
								acc_q       <= '0;
								cnt_q       <= '0;
								phase_col_q <= ~phase_col_q;
								second_q    <= 1'b0;
							end else begin
								res_set_q <= acc_q;
								st_q      <= S_DONE;
							end
						end
					end
				end
				S_DONE: begin
					if (res_take) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign idle           = (st_q == S_IDLE);
	assign res_valid      = (st_q == S_DONE);
	assign res.result_set = res_set_q[RES_W-1:0];
	assign res.cell_bit   = bit_q;
	assign res.status     = status_q;

	a_both_copies: assert property (@(posedge clk) disable iff (!arst_n)
		row_we |-> col_we && (row_addr == OBJ_AW'(oi_q)) && (col_addr == ATTR_AW'(ai_q)))
		else $error("cell write does not update both copies of the same cell");

	a_pend_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> st_q == S_WALK)
		else $error("store read still pending outside a walk");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_WALK |-> cnt_q <= limit)
		else $error("walk counter passed the count in use");

	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_WALK |-> (acc_q & ~low_mask(limit)) == '0)
		else $error("derived set holds a member beyond the count in use");

endmodule

### rtl/formal_context_closure_engine_core.sv
// Top level of the formal context closure engine: ports, item intake and output register.
//
// The engine holds one item at a time. A cell write, cell read, object row or attribute
// column read goes from transfer to result through a store read, then the result; an
// out-of-range item goes straight to the result. A derivation walks the N stored rows
// or columns through the single port of its store, one entry a cycle, N being
// the object count for an attribute query and the attribute count for an object query;
// a closure runs both walks back to back. The stores read as all zero right after reset
// without a clearing pass. The output register holds a finished result while the next
// item is already taken in. The count registers are to be written only while the engine
// is idle; the user is bound by this, and the block itself does not enforce it.
module formal_context_closure_engine_core import fcce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        kind,
	input  logic [IDX_W-1:0]  obj_index,
	input  logic [IDX_W-1:0]  attr_index,
	input  logic              cell_value,
	input  logic [RES_W-1:0]  query_set,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [RES_W-1:0]  result_set,
	output logic              cell_bit,
	output logic              status,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	cfg_t  cfg;
	item_t item;
	res_t  eng_res;
	logic  eng_idle;
	logic  eng_valid;
	logic  eng_take;
	logic  start;
	logic  out_valid_q;
	res_t  out_q;

	fcce_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign item.kind       = kind;
	assign item.obj_index  = obj_index;
	assign item.attr_index = attr_index;
	assign item.cell_value = cell_value;
	assign item.query_set  = query_set;

	assign in_stall = !eng_idle;
	assign start    = in_valid && !in_stall;

	fcce_eng u_eng (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.cfg       (cfg),
		.idle      (eng_idle),
		.res_valid (eng_valid),
		.res_take  (eng_take),
		.res       (eng_res)
	);

	// A result moves into the output register when it is empty or being emptied.
	assign eng_take = eng_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (eng_take) begin
				out_valid_q <= 1'b1;
				out_q       <= eng_res;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign result_set = out_q.result_set;
	assign cell_bit   = out_q.cell_bit;
	assign status     = out_q.status;

endmodule

### sim/formal_context_closure_engine_core_tb.sv
// Self-checking testbench of the formal context closure engine: directed table, then random phases.
`timescale 1ns / 100ps

module formal_context_closure_engine_core_tb;
	import fcce_pkg::*;

	localparam int LIMIT_CYCLES  = 1000000;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASES        = 14;
	localparam int PHASE_ITEMS   = 125;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [2:0]        kind;
	logic [IDX_W-1:0]  obj_index;
	logic [IDX_W-1:0]  attr_index;
	logic              cell_value;
	logic [RES_W-1:0]  query_set;
	logic              out_valid;
	logic              out_stall;
	logic [RES_W-1:0]  result_set;
	logic              cell_bit;
	logic              status;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic              pready;

	formal_context_closure_engine_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .obj_index(obj_index), .attr_index(attr_index),
		.cell_value(cell_value), .query_set(query_set),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_set(result_set), .cell_bit(cell_bit), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the incidence matrix and the count registers.
	logic [ROW_W-1:0] obj_rows [MAX_OBJECTS];
	logic [COL_W-1:0] attr_cols [MAX_ATTRIBUTES];
	logic [CNT_W-1:0] object_count;
	logic [CNT_W-1:0] attribute_count;

	res_t pending_responses [$];
	int   mismatches = 0;
	int   cycles = 0;
	bit   idling_on = 1'b1;
	bit   hold_request = 1'b0;

	typedef struct {
		bit               is_cfg;
		logic [CNT_W-1:0] oc;
		logic [CNT_W-1:0] ac;
		logic [2:0]       k;
		logic [IDX_W-1:0] oi;
		logic [IDX_W-1:0] ai;
		logic             v;
		logic [RES_W-1:0] q;
		bit               typed;
		logic [RES_W-1:0] e_res;
		logic             e_bit;
		logic             e_st;
	} step_t;

	step_t directed_steps [$];

	function automatic int eff_objects();
		return (int'(object_count) > MAX_OBJECTS) ? MAX_OBJECTS : int'(object_count);
	endfunction

	function automatic int eff_attributes();
		return (int'(attribute_count) > MAX_ATTRIBUTES) ? MAX_ATTRIBUTES : int'(attribute_count);
	endfunction

	function automatic logic [31:0] count_mask(input int n);
		if (n >= 32) return '1;
		return (32'd1 << n) - 32'd1;
	endfunction

	// Objects whose row holds every queried attribute in use.
	function automatic logic [31:0] objects_holding(input logic [31:0] q);
		logic [31:0] am;
		logic [31:0] qs;
		logic [31:0] r;
		int no;
		r = '0;
		no = eff_objects();
		am = count_mask(eff_attributes());
		qs = q & am;
		for (int i = 0; i < no; i++) begin
			if ((qs & ~(obj_rows[i] & am)) == '0) r[i] = 1'b1;
		end
		return r;
	endfunction

	// Attributes whose column holds every queried object in use.
	function automatic logic [31:0] attributes_shared(input logic [31:0] q);
		logic [31:0] om;
		logic [31:0] qs;
		logic [31:0] r;
		int na;
		r = '0;
		na = eff_attributes();
		om = count_mask(eff_objects());
		qs = q & om;
		for (int i = 0; i < na; i++) begin
			if ((qs & ~(attr_cols[i] & om)) == '0) r[i] = 1'b1;
		end
		return r;
	endfunction

	function automatic res_t predict_response(input logic [2:0] k, input logic [IDX_W-1:0] oi,
			input logic [IDX_W-1:0] ai, input logic v, input logic [31:0] q);
		res_t r;
		bit obj_ok;
		bit attr_ok;
		r = '0;
		obj_ok = int'(oi) < eff_objects();
		attr_ok = int'(ai) < eff_attributes();
		case (k)
			KIND_WRITE_CELL: begin
				if (obj_ok && attr_ok) begin
					obj_rows[oi][ai] = v;
					attr_cols[ai][oi] = v;
				end else begin
					r.status = STATUS_RANGE;
				end
			end
			KIND_READ_CELL: begin
				if (obj_ok && attr_ok) r.cell_bit = obj_rows[oi][ai];
				else r.status = STATUS_RANGE;
			end
			KIND_OBJ_ROW: begin
				if (obj_ok) r.result_set = obj_rows[oi] & count_mask(eff_attributes());
				else r.status = STATUS_RANGE;
			end
			KIND_ATTR_COL: begin
				if (attr_ok) r.result_set = attr_cols[ai] & count_mask(eff_objects());
				else r.status = STATUS_RANGE;
			end
			KIND_DERIVE_ATTR: r.result_set = objects_holding(q);
			KIND_DERIVE_OBJ:  r.result_set = attributes_shared(q);
			KIND_CLOSE_ATTR:  r.result_set = attributes_shared(objects_holding(q));
			default:          r.result_set = objects_holding(attributes_shared(q));
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
		mismatches++;
	endtask

	function automatic void add_step(input logic [2:0] k, input logic [IDX_W-1:0] oi,
			input logic [IDX_W-1:0] ai, input logic v, input logic [31:0] q, input bit typed,
			input logic [31:0] e_res, input logic e_bit, input logic e_st);
		step_t s;
		s = '{is_cfg: 1'b0, oc: '0, ac: '0, k: k, oi: oi, ai: ai, v: v, q: q,
			typed: typed, e_res: e_res, e_bit: e_bit, e_st: e_st};
		directed_steps.push_back(s);
	endfunction

	function automatic void add_counts(input logic [CNT_W-1:0] oc, input logic [CNT_W-1:0] ac);
		step_t s;
		s = '{is_cfg: 1'b1, oc: oc, ac: ac, k: '0, oi: '0, ai: '0, v: 1'b0, q: '0,
			typed: 1'b0, e_res: '0, e_bit: 1'b0, e_st: 1'b0};
		directed_steps.push_back(s);
	endfunction

	// Offers one item, waits for its transfer and records what it should return.
	task automatic push_item(input logic [2:0] k, input logic [IDX_W-1:0] oi,
			input logic [IDX_W-1:0] ai, input logic v, input logic [31:0] q, input bit typed,
			input res_t typed_res);
		res_t predicted;
		in_valid <= 1'b1;
		kind <= k;
		obj_index <= oi;
		attr_index <= ai;
		cell_value <= v;
		query_set <= q;
		do @(posedge clk); while (in_stall);
		predicted = predict_response(k, oi, ai, v, q);
		pending_responses.push_back(typed ? typed_res : predicted);
		if (idling_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Stops offering items and lets every outstanding result come out.
	task automatic settle_engine();
		in_valid <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic idx, input logic [CNT_W-1:0] value);
		logic [31:0] word;
		word = $urandom();
		word[CNT_W-1:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_AW'({idx, 2'b00});
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_OBJECT_COUNT) object_count = value;
		else attribute_count = value;
		@(posedge clk);
	endtask

	task automatic apply_counts(input logic [CNT_W-1:0] oc, input logic [CNT_W-1:0] ac);
		settle_engine();
		write_count(REG_OBJECT_COUNT, oc);
		write_count(REG_ATTRIBUTE_COUNT, ac);
	endtask

	task automatic run_random_phase(input int n);
		int no;
		int na;
		int pick;
		int src;
		bit attr_query;
		logic [2:0] k;
		logic [IDX_W-1:0] oi;
		logic [IDX_W-1:0] ai;
		logic v;
		logic [31:0] q;
		for (int n_done = 0; n_done < n; n_done++) begin
			no = eff_objects();
			na = eff_attributes();
			pick = $urandom_range(0, 99);
			if (pick < 35) k = KIND_WRITE_CELL;
			else if (pick < 45) k = KIND_READ_CELL;
			else if (pick < 53) k = KIND_OBJ_ROW;
			else if (pick < 61) k = KIND_ATTR_COL;
			else if (pick < 71) k = KIND_DERIVE_ATTR;
			else if (pick < 81) k = KIND_DERIVE_OBJ;
			else if (pick < 91) k = KIND_CLOSE_ATTR;
			else k = KIND_CLOSE_OBJ;
			oi = (no > 0 && $urandom_range(0, 99) < 85) ? IDX_W'($urandom_range(0, no - 1))
				: IDX_W'($urandom_range(0, 31));
			ai = (na > 0 && $urandom_range(0, 99) < 85) ? IDX_W'($urandom_range(0, na - 1))
				: IDX_W'($urandom_range(0, 31));
			v = $urandom_range(0, 99) < 65;
			attr_query = (k == KIND_DERIVE_ATTR || k == KIND_CLOSE_ATTR);
			src = $urandom_range(0, 9);
			// Queries taken from a stored row or column give closures that are not trivial.
			if (src < 6) begin
				q = attr_query ? obj_rows[$urandom_range(0, MAX_OBJECTS - 1)]
					: attr_cols[$urandom_range(0, MAX_ATTRIBUTES - 1)];
				q = q & ($urandom() | $urandom());
				if ($urandom_range(0, 2) == 0)
					q = q | ($urandom() & ~count_mask(attr_query ? na : no));
			end else if (src < 8) begin
				q = $urandom() & $urandom() & $urandom();
			end else if (src == 8) begin
				q = $urandom();
			end else begin
				q = '0;
			end
			push_item(k, oi, ai, v, q, 1'b0, '0);
		end
	endtask

	// Result side: checks each transfer and stalls in bursts or for one long hold-off.
	initial begin : response_side
		res_t want;
		int burst_left;
		int hold_left;
		burst_left = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_responses.size() == 0) begin
					report_mismatch("result with nothing pending", result_set, 32'd0);
				end else begin
					want = pending_responses.pop_front();
					if (result_set !== want.result_set)
						report_mismatch("result_set", result_set, want.result_set);
					if (cell_bit !== want.cell_bit)
						report_mismatch("cell_bit", 32'(cell_bit), 32'(want.cell_bit));
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				out_stall <= 1'b1;
			end else if (idling_on && $urandom_range(0, 9) == 0) begin
				burst_left = $urandom_range(1, 4) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("[formal_context_closure_engine_core] ERROR");
		$finish;
	end

	initial begin : stimulus
		res_t typed_res;
		step_t s;
		logic [CNT_W-1:0] oc;
		logic [CNT_W-1:0] ac;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= '0;
		obj_index <= '0;
		attr_index <= '0;
		cell_value <= 1'b0;
		query_set <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		for (int i = 0; i < MAX_OBJECTS; i++) obj_rows[i] = '0;
		for (int i = 0; i < MAX_ATTRIBUTES; i++) attr_cols[i] = '0;
		object_count = CNT_W'(32);
		attribute_count = CNT_W'(32);

		// Empty store at full counts, then corner cells.
		add_step(KIND_READ_CELL, 0, 0, 1'b1, '1, 1, 32'h0, 1'b0, STATUS_OK);
		add_step(KIND_OBJ_ROW, 31, 5, 1'b0, 32'h0, 1, 32'h0, 1'b0, STATUS_OK);
		add_step(KIND_DERIVE_ATTR, 3, 3, 1'b0, 32'h0, 1, 32'hFFFF_FFFF, 1'b0, STATUS_OK);
		add_step(KIND_DERIVE_OBJ, 0, 0, 1'b0, 32'hFFFF_FFFF, 1, 32'h0, 1'b0, STATUS_OK);
		add_step(KIND_WRITE_CELL, 0, 0, 1'b1, 32'h0, 1, 32'h0, 1'b0, STATUS_OK);
		add_step(KIND_WRITE_CELL, 31, 31, 1'b1, 32'hFFFF_FFFF, 1, 32'h0, 1'b0, STATUS_OK);
		add_step(KIND_WRITE_CELL, 31, 0, 1'b1, 32'h0, 0, 32'h0, 1'b0, STATUS_OK);
		add_step(KIND_WRITE_CELL, 0, 31, 1'b1, 32'h0, 0, 32'h0, 1'b0, STATUS_OK);
		add_step(KIND_READ_CELL, 31, 31, 1'b0, 32'h0, 1, 32'h0, 1'b1, STATUS_OK);
		add_step(KIND_OBJ_ROW, 0, 0, 1'b0, 32'h0, 0, 32'h0, 1'b0, STATUS_OK);
		add_step(KIND_ATTR_COL, 0, 31, 1'b0, 32'h0, 0, 32'h0, 1'b0, STATUS_OK);
		add_step(KIND_DERIVE_ATTR, 0, 0, 1'b0, 32'h8000_0001, 0, 32'h0, 1'b0, STATUS_OK);
		add_step(KIND_DERIVE_OBJ, 0, 0, 1'b0, 32'h8000_0001, 0, 32'h0, 1'b0, STATUS_OK);
		add_step(KIND_CLOSE_ATTR, 0, 0, 1'b0, 32'h0000_0001, 0, 32'h0, 1'b0, STATUS_OK);
		add_step(KIND_CLOSE_OBJ, 0, 0, 1'b0, 32'h8000_0000, 0, 32'h0, 1'b0, STATUS_OK);
		// Shrunk counts: range errors, ignored indices, query bits beyond the counts.
		add_counts(4, 3);
		add_step(KIND_WRITE_CELL, 4, 0, 1'b1, 32'h0, 1, 32'h0, 1'b0, STATUS_RANGE);
		add_step(KIND_WRITE_CELL, 0, 3, 1'b1, 32'h0, 1, 32'h0, 1'b0, STATUS_RANGE);
		add_step(KIND_READ_CELL, 31, 31, 1'b0, 32'h0, 1, 32'h0, 1'b0, STATUS_RANGE);
		add_step(KIND_OBJ_ROW, 4, 0, 1'b0, 32'h0, 1, 32'h0, 1'b0, STATUS_RANGE);
		add_step(KIND_ATTR_COL, 0, 3, 1'b0, 32'h0, 1, 32'h0, 1'b0, STATUS_RANGE);
		add_step(KIND_OBJ_ROW, 3, 31, 1'b0, 32'h0, 0, 32'h0, 1'b0, STATUS_OK);
		add_step(KIND_ATTR_COL, 31, 2, 1'b0, 32'h0, 0, 32'h0, 1'b0, STATUS_OK);
		add_step(KIND_DERIVE_ATTR, 0, 0, 1'b0, 32'hFFFF_FFF8, 1, 32'h0000_000F, 1'b0,
			STATUS_OK);
		add_step(KIND_DERIVE_OBJ, 0, 0, 1'b0, 32'hFFFF_FFF0, 1, 32'h0000_0007, 1'b0,
			STATUS_OK);
		// Counts above the store depth act as the depth; zero counts leave nothing in use.
		add_counts(63, 63);
		add_step(KIND_DERIVE_ATTR, 0, 0, 1'b0, 32'h0, 1, 32'hFFFF_FFFF, 1'b0, STATUS_OK);
		add_counts(0, 0);
		add_step(KIND_DERIVE_ATTR, 0, 0, 1'b0, 32'h0, 1, 32'h0, 1'b0, STATUS_OK);
		add_step(KIND_CLOSE_OBJ, 0, 0, 1'b0, 32'hFFFF_FFFF, 0, 32'h0, 1'b0, STATUS_OK);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			s = directed_steps[i];
			if (s.is_cfg) begin
				apply_counts(s.oc, s.ac);
			end else begin
				typed_res.result_set = s.e_res;
				typed_res.cell_bit = s.e_bit;
				typed_res.status = s.e_st;
				push_item(s.k, s.oi, s.ai, s.v, s.q, s.typed, typed_res);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin oc = 32; ac = 32; end
				1: begin oc = 0; ac = 0; end
				2: begin oc = 63; ac = 63; end
				3: begin oc = 1; ac = 1; end
				4: begin oc = 32; ac = 1; end
				5: begin oc = 1; ac = 32; end
				PHASES - 1: begin oc = 32; ac = 32; end
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						oc = CNT_W'($urandom_range(0, 63));
						ac = CNT_W'($urandom_range(0, 63));
					end else begin
						oc = CNT_W'($urandom_range(2, 12));
						ac = CNT_W'($urandom_range(2, 12));
					end
				end
			endcase
			apply_counts(oc, ac);
			if (p == PHASES - 1) idling_on = 1'b0;
			// The result side holds off while items keep coming, so the engine backs up.
			if (p == 2) hold_request = 1'b1;
			run_random_phase(PHASE_ITEMS);
		end

		settle_engine();
		if (mismatches == 0) begin
			$display("[formal_context_closure_engine_core] OK");
		end else begin
			$display("[formal_context_closure_engine_core] ERROR");
		end
		$finish;
	end

endmodule
